[rtl/core/spls_pkg.sv]
`timescale 1ns / 1ps

package spls_pkg;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } op_e;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [5:0]  entry_id;
    logic [31:0] entry_priority;
    logic [31:0] entry_avail;
    logic [63:0] entry_tag;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        head_valid;
    logic [5:0]  head_id;
    logic [31:0] head_priority;
    logic [31:0] head_avail;
    logic [63:0] head_tag;
  } rsp_t;

  typedef struct packed {
    logic       capture;
    logic       start_add;
    logic       rd_en;
    logic       rd_sel_next;
    logic       step;
    logic       link_id;
    logic       link_prev;
    logic       pop;
    logic       set_status;
    logic [1:0] status;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic is_add;
    logic is_pop;
    logic add_ok;
    logic head_empty;
    logic walk_go;
    logic walk_more;
    logic out_busy;
  } stat_t;

endpackage

[rtl/core/spls_ctrl.sv]
`timescale 1ns / 1ps

module spls_ctrl import spls_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  req_valid_i,
  output logic  req_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_LINK_ID,
    S_LINK_PREV,
    S_POP,
    S_HEAD_RD,
    S_RESP
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat_i.is_add) begin
          if (stat_i.add_ok) begin
            cmd_o.start_add = 1'b1;
            if (stat_i.head_empty) begin
              state_d = S_LINK_ID;
            end else begin
              cmd_o.rd_en = 1'b1;
              state_d     = S_WALK;
            end
          end else begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_REJECT;
            state_d          = S_HEAD_RD;
          end
        end else if (stat_i.is_pop) begin
          if (stat_i.head_empty) begin
            cmd_o.set_status = 1'b1;
            cmd_o.status     = ST_EMPTY;
            state_d          = S_HEAD_RD;
          end else begin
            cmd_o.rd_en = 1'b1;
            state_d     = S_POP;
          end
        end else begin
          state_d = S_HEAD_RD;
        end
      end
      S_WALK: begin
        if (stat_i.walk_go) begin
          cmd_o.step = 1'b1;
          if (stat_i.walk_more) begin
            cmd_o.rd_en       = 1'b1;
            cmd_o.rd_sel_next = 1'b1;
          end else begin
            state_d = S_LINK_ID;
          end
        end else begin
          state_d = S_LINK_ID;
        end
      end
      S_LINK_ID: begin
        cmd_o.link_id = 1'b1;
        state_d       = S_LINK_PREV;
      end
      S_LINK_PREV: begin
        cmd_o.link_prev = 1'b1;
        state_d         = S_HEAD_RD;
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = S_HEAD_RD;
      end
      S_HEAD_RD: begin
        cmd_o.rd_en = !stat_i.head_empty;
        state_d     = S_RESP;
      end
      S_RESP: begin
        if (!stat_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/spls_datapath.sv]
`timescale 1ns / 1ps

module spls_datapath import spls_pkg::*; #(
  parameter int NUM_SLOTS     = 64,
  parameter int PRIORITY_BITS = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  req_t  req_i,
  input  cmd_t  cmd_i,
  output stat_t stat_o,
  output logic  rsp_valid_o,
  input  logic  rsp_ready_i,
  output rsp_t  rsp_o
);

  localparam int PTR_W = $clog2(NUM_SLOTS + 1);
  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int EXT_W = (PRIORITY_BITS > 32) ? PRIORITY_BITS : 32;
  localparam int ROW_W = PRIORITY_BITS + 32 + 64;
  localparam logic [PTR_W-1:0] NONE = PTR_W'(NUM_SLOTS);

  // entry storage
  logic [ROW_W-1:0] row_mem [NUM_SLOTS];
  logic [PTR_W-1:0] nxt_mem [NUM_SLOTS];

  logic [1:0]               op_q;
  logic [5:0]               id_q;
  logic [PRIORITY_BITS-1:0] prio_q;
  logic [31:0]              avail_q;
  logic [63:0]              tag_q;
  logic [1:0]               status_q;

  logic [PTR_W-1:0]  head_q;
  logic [PTR_W-1:0]  prev_q;
  logic [PTR_W-1:0]  cur_q;
  logic [PTR_W-1:0]  steps_q;
  logic [NUM_SLOTS-1:0] queued_q;

  logic [ROW_W-1:0] row_rd_q;
  logic [PTR_W-1:0] nxt_rd_q;

  logic out_valid_q;
  rsp_t out_q;

  logic [EXT_W-1:0]         prio_in_ext;
  logic [PRIORITY_BITS-1:0] rd_prio;
  logic [EXT_W-1:0]         rd_prio_ext;
  logic [31:0]              rd_avail;
  logic [63:0]              rd_tag;
  logic [PTR_W-1:0]         id_ptr;
  logic [PTR_W-1:0]         rd_addr;
  logic [PTR_W-1:0]         pop_next;
  logic                     id_in_range;
  logic                     nxt_we;
  logic [PTR_W-1:0]         nxt_waddr;
  logic [PTR_W-1:0]         nxt_wdata;

  assign prio_in_ext = EXT_W'(req_i.entry_priority);
  assign rd_prio     = row_rd_q[ROW_W-1 -: PRIORITY_BITS];
  assign rd_prio_ext = EXT_W'(rd_prio);
  assign rd_avail    = row_rd_q[95:64];
  assign rd_tag      = row_rd_q[63:0];

  assign id_in_range = (32'(id_q) < 32'(NUM_SLOTS));
  assign id_ptr      = PTR_W'(id_q);
  assign rd_addr     = cmd_i.rd_sel_next ? nxt_rd_q : head_q;
  assign pop_next    = (nxt_rd_q > NONE) ? NONE : nxt_rd_q;

  // status towards the controller
  assign stat_o.is_add     = (op_q == OP_ADD);
  assign stat_o.is_pop     = (op_q == OP_POP);
  assign stat_o.add_ok     = id_in_range && !queued_q[id_ptr[IDX_W-1:0]];
  assign stat_o.head_empty = (head_q >= NONE);
  assign stat_o.walk_go    = (rd_prio >= prio_q) && (steps_q < NONE);
  assign stat_o.walk_more  = (nxt_rd_q < NONE) && (steps_q < NONE - PTR_W'(1));
  assign stat_o.out_busy   = out_valid_q && !rsp_ready_i;

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= req_i.operation;
      id_q    <= req_i.entry_id;
      prio_q  <= prio_in_ext[PRIORITY_BITS-1:0];
      avail_q <= req_i.entry_avail;
      tag_q   <= req_i.entry_tag;
    end
    if (cmd_i.capture) begin
      status_q <= ST_OK;
    end else if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
  end

  // walk pointers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_add) begin
      prev_q  <= NONE;
      cur_q   <= head_q;
      steps_q <= '0;
    end else if (cmd_i.step) begin
      prev_q  <= cur_q;
      cur_q   <= nxt_rd_q;
      steps_q <= steps_q + PTR_W'(1);
    end
  end

  // list head and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= NONE;
      queued_q <= '0;
    end else begin
      if (cmd_i.link_id) begin
        queued_q[id_ptr[IDX_W-1:0]] <= 1'b1;
      end
      if (cmd_i.link_prev && (prev_q >= NONE)) begin
        head_q <= id_ptr;
      end
      if (cmd_i.pop) begin
        head_q                      <= pop_next;
        queued_q[head_q[IDX_W-1:0]] <= 1'b0;
      end
    end
  end

  // link memory write port
  always_comb begin
    nxt_we    = 1'b0;
    nxt_waddr = head_q;
    nxt_wdata = NONE;
    if (cmd_i.link_id) begin
      nxt_we    = 1'b1;
      nxt_waddr = id_ptr;
      nxt_wdata = cur_q;
    end else if (cmd_i.link_prev && (prev_q < NONE)) begin
      nxt_we    = 1'b1;
      nxt_waddr = prev_q;
      nxt_wdata = id_ptr;
    end else if (cmd_i.pop) begin
      nxt_we    = 1'b1;
      nxt_waddr = head_q;
      nxt_wdata = NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (nxt_we) begin
      nxt_mem[nxt_waddr[IDX_W-1:0]] <= nxt_wdata;
    end
    if (cmd_i.rd_en) begin
      nxt_rd_q <= nxt_mem[rd_addr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_add) begin
      row_mem[id_ptr[IDX_W-1:0]] <= {prio_q, avail_q, tag_q};
    end
    if (cmd_i.rd_en) begin
      row_rd_q <= row_mem[rd_addr[IDX_W-1:0]];
    end
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.status <= status_q;
      if (head_q < NONE) begin
        out_q.head_valid    <= 1'b1;
        out_q.head_id       <= 6'(head_q);
        out_q.head_priority <= rd_prio_ext[31:0];
        out_q.head_avail    <= rd_avail;
        out_q.head_tag      <= rd_tag;
      end else begin
        out_q.head_valid    <= 1'b0;
        out_q.head_id       <= '0;
        out_q.head_priority <= '0;
        out_q.head_avail    <= '0;
        out_q.head_tag      <= '0;
      end
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

`ifndef SYNTHESIS
  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= NONE)
    else $error("head pointer out of range");

  a_head_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_q < NONE) |-> queued_q[head_q[IDX_W-1:0]])
    else $error("head slot not marked queued");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !(out_valid_q && !rsp_ready_i))
    else $error("response overwritten while stalled");

  a_step_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> $past(cmd_i.rd_en))
    else $error("walk step without fresh read data");
`endif

endmodule

[rtl/core/sorted_priority_list_scheduler.sv]
// steps: peek and rejected add read the head; pop unlinks a queued head, then reads the new head;
// add walks queued entries (at most NUM_SLOTS reads), links the entry, then reads the head
// throughput: one request at a time, next one taken in the cycle after the response loads;
// the load waits while the previous response is still held, an add is bounded by the walk
// reset: asynchronous active low, empties the queue; slot storage is not cleared
`timescale 1ns / 1ps

module sorted_priority_list_scheduler import spls_pkg::*; #(
  parameter int NUM_SLOTS     = 64,
  parameter int PRIORITY_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  cmd_t  cmd;
  stat_t stat;

  spls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  spls_datapath #(
    .NUM_SLOTS     (NUM_SLOTS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o)
  );

endmodule

[tb/sv/spls_checker.sv]
`timescale 1ns / 1ps

module spls_checker import spls_pkg::*; #(
  parameter int NUM_SLOTS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  logic req_ready_i,
  input  req_t req_i,
  input  logic rsp_valid_i,
  input  logic rsp_ready_i,
  input  rsp_t rsp_i,
  output int   fail_count_o,
  output int   outstanding_o,
  output int   max_depth_o
);

  localparam int NIL = NUM_SLOTS;

  int          head_idx = NIL;
  int          slot_next  [NUM_SLOTS];
  logic [31:0] slot_prio  [NUM_SLOTS];
  logic [31:0] slot_avail [NUM_SLOTS];
  logic [63:0] slot_tag   [NUM_SLOTS];
  bit          slot_busy  [NUM_SLOTS];
  int          depth      = 0;
  int          deepest    = 0;
  int          fails      = 0;
  int          waiting    = 0;
  rsp_t        expected_rsp_q [$];

  assign fail_count_o  = fails;
  assign outstanding_o = waiting;
  assign max_depth_o   = deepest;

  // walks the sorted list the way the block does; equal priorities stay in arrival order
  function automatic rsp_t apply_request(req_t r);
    rsp_t res;
    int   prev;
    int   cur;
    int   steps;
    int   id;
    res        = '0;
    res.status = ST_OK;
    id         = int'(r.entry_id);
    if (r.operation == OP_ADD) begin
      if (id >= NUM_SLOTS || slot_busy[id]) begin
        res.status = ST_REJECT;
      end else begin
        slot_prio[id]  = r.entry_priority;
        slot_avail[id] = r.entry_avail;
        slot_tag[id]   = r.entry_tag;
        prev  = NIL;
        cur   = head_idx;
        steps = 0;
        while (cur != NIL && steps < NUM_SLOTS && slot_prio[cur] >= r.entry_priority) begin
          prev = cur;
          cur  = slot_next[cur];
          steps++;
        end
        if (prev == NIL) begin
          slot_next[id] = head_idx;
          head_idx      = id;
        end else begin
          slot_next[id]   = slot_next[prev];
          slot_next[prev] = id;
        end
        slot_busy[id] = 1'b1;
        depth++;
      end
    end else if (r.operation == OP_POP) begin
      if (head_idx == NIL) begin
        res.status = ST_EMPTY;
      end else begin
        cur            = head_idx;
        head_idx       = slot_next[cur];
        slot_next[cur] = NIL;
        slot_busy[cur] = 1'b0;
        depth--;
      end
    end
    if (head_idx != NIL) begin
      res.head_valid    = 1'b1;
      res.head_id       = 6'(head_idx);
      res.head_priority = slot_prio[head_idx];
      res.head_avail    = slot_avail[head_idx];
      res.head_tag      = slot_tag[head_idx];
    end
    return res;
  endfunction

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_next[i]  = NIL;
      slot_prio[i]  = '0;
      slot_avail[i] = '0;
      slot_tag[i]   = '0;
      slot_busy[i]  = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_rsp_q.size() == 0) begin
          $error("response with no request waiting");
          fails++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_i.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, rsp_i.status);
            fails++;
          end
          if (rsp_i.head_valid !== want.head_valid) begin
            $error("head_valid mismatch: expected %0d, got %0d",
                   want.head_valid, rsp_i.head_valid);
            fails++;
          end
          if (rsp_i.head_id !== want.head_id) begin
            $error("head_id mismatch: expected %0d, got %0d", want.head_id, rsp_i.head_id);
            fails++;
          end
          if (rsp_i.head_priority !== want.head_priority) begin
            $error("head_priority mismatch: expected %h, got %h",
                   want.head_priority, rsp_i.head_priority);
            fails++;
          end
          if (rsp_i.head_avail !== want.head_avail) begin
            $error("head_avail mismatch: expected %h, got %h",
                   want.head_avail, rsp_i.head_avail);
            fails++;
          end
          if (rsp_i.head_tag !== want.head_tag) begin
            $error("head_tag mismatch: expected %h, got %h", want.head_tag, rsp_i.head_tag);
            fails++;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        expected_rsp_q.push_back(apply_request(req_i));
        if (depth > deepest) deepest = depth;
      end
      waiting = expected_rsp_q.size();
    end
  end

endmodule

[tb/sv/sorted_priority_list_scheduler_tb.sv]
`timescale 1ns / 1ps

module sorted_priority_list_scheduler_tb;
  import spls_pkg::*;

  localparam int         NUM_SLOTS       = 64;
  localparam int         N_RANDOM        = 2000;
  localparam int         MAX_GAP         = 12;
  localparam int         IDLE_LIMIT      = 5000;
  localparam int         DRAIN_LIMIT     = 20000;
  localparam int         TAIL_CYCLES     = 80;
  localparam int         HOLD_OFF_AT     = 500;
  localparam int         HOLD_OFF_CYCLES = 400;
  localparam logic [1:0] OP_SPARE        = 2'd3;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int fails;
  int outstanding;
  int deepest;
  int n_add       = 0;
  int n_pop       = 0;
  int n_peek      = 0;
  int rsp_taken   = 0;
  int idle_cycles = 0;
  bit no_idle     = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sorted_priority_list_scheduler #(
    .NUM_SLOTS     (NUM_SLOTS),
    .PRIORITY_BITS (32)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .rsp_valid_o (rsp_valid),
    .rsp_ready_i (rsp_ready),
    .rsp_o       (rsp)
  );

  spls_checker #(
    .NUM_SLOTS (NUM_SLOTS)
  ) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_valid),
    .req_ready_i   (req_ready),
    .req_i         (req),
    .rsp_valid_i   (rsp_valid),
    .rsp_ready_i   (rsp_ready),
    .rsp_i         (rsp),
    .fail_count_o  (fails),
    .outstanding_o (outstanding),
    .max_depth_o   (deepest)
  );

  always @(posedge clk_i) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("sorted_priority_list_scheduler_tb failed");
      $finish;
    end
  end

  function automatic req_t noise_request(logic [1:0] op);
    req_t r;
    r.operation      = op;
    r.entry_id       = 6'($urandom);
    r.entry_priority = $urandom;
    r.entry_avail    = $urandom;
    r.entry_tag      = {$urandom, $urandom};
    return r;
  endfunction

  function automatic req_t add_request(int id, logic [31:0] prio, logic [31:0] avail,
                                       logic [63:0] tag);
    req_t r;
    r.operation      = OP_ADD;
    r.entry_id       = 6'(id);
    r.entry_priority = prio;
    r.entry_avail    = avail;
    r.entry_tag      = tag;
    return r;
  endfunction

  // fill, drain and mixed phases; narrow priorities give plenty of ties
  function automatic req_t random_request(int phase);
    req_t r;
    int   roll;
    int   add_pct;
    r       = noise_request(OP_PEEK);
    roll    = $urandom_range(0, 99);
    add_pct = (phase == 0) ? 70 : (phase == 1) ? 25 : 45;
    if (roll < add_pct) r.operation = OP_ADD;
    else if (roll < 88) r.operation = OP_POP;
    else if (roll < 97) r.operation = OP_PEEK;
    else r.operation = OP_SPARE;
    case ($urandom_range(0, 4))
      0, 1: r.entry_priority = $urandom_range(0, 7);
      2: r.entry_priority = $urandom_range(0, 1) ? '1 : '0;
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_request(input req_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk_i); while (!req_ready);
    case (r.operation)
      OP_ADD: n_add++;
      OP_POP: n_pop++;
      default: n_peek++;
    endcase
  endtask

  // receiver, with one long hold-off so the block backs up
  initial begin
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rsp_taken == HOLD_OFF_AT) gap = HOLD_OFF_CYCLES;
      else if (no_idle) gap = 0;
      else gap = $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_valid);
      rsp_taken++;
    end
  end

  initial begin
    int phase;
    int waited;
    phase = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue
    send_request(noise_request(OP_PEEK));
    send_request(noise_request(OP_POP));
    send_request(noise_request(OP_SPARE));
    // field extremes
    send_request(add_request(0, '0, '0, '0));
    send_request(add_request(63, '1, '1, '1));
    // equal priorities leave in arrival order
    send_request(add_request(5, 32'd100, 32'h5555_5555, 64'hAAAA_AAAA_5555_5555));
    send_request(add_request(6, 32'd100, 32'hAAAA_AAAA, 64'h5555_5555_AAAA_AAAA));
    send_request(add_request(7, 32'd100, 32'h0000_0007, 64'h0123_4567_89AB_CDEF));
    // duplicate adds
    send_request(add_request(0, '1, 32'h1234_5678, 64'hDEAD_BEEF_0000_0001));
    send_request(add_request(63, 32'd1, 32'h8765_4321, 64'h0000_0001_DEAD_BEEF));
    send_request(add_request(8, '1, 32'h0F0F_0F0F, 64'hF0F0_F0F0_0F0F_0F0F));
    send_request(noise_request(OP_PEEK));
    send_request(noise_request(OP_SPARE));
    repeat (7) send_request(noise_request(OP_POP));
    send_request(noise_request(OP_POP));

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0) begin
        phase   = $urandom_range(0, 2);
        no_idle = ($urandom_range(0, 3) == 0);
      end
      send_request(random_request(phase));
    end
    req_valid <= 1'b0;

    @(posedge clk_i);
    waited = 0;
    while (outstanding != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (outstanding != 0) begin
      $display("sorted_priority_list_scheduler_tb failed");
      $finish;
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk_i);
      $display("run covered %0d requests: %0d adds, %0d pops, %0d peeks",
               n_add + n_pop + n_peek, n_add, n_pop, n_peek);
      $display("deepest list reached %0d entries, with one long receiver hold-off", deepest);
      if (fails == 0 && outstanding == 0) begin
        $display("sorted_priority_list_scheduler_tb passed");
      end else begin
        $display("sorted_priority_list_scheduler_tb failed");
      end
      $finish;
    end
  end

endmodule
